// ===== src/obpt_pkg.sv =====
// Shared types and constants of the onset and beat phase tracker.
package obpt_pkg;

   localparam int FLUX_FIELD_BITS  = 24;
   localparam int PERIOD_BITS      = 16;
   localparam int STRENGTH_BITS    = 16;
   localparam int PHASE_TURNS_BITS = 32;
   localparam int REQ_TDATA_BITS   = 40;
   localparam int RSP_TDATA_BITS   = 56;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int CSR_DATA_BITS    = 16;

   localparam logic [11:0] ONSET_FACTOR_RESET   = 12'd410;
   localparam logic [15:0] PHASE_GAIN_RESET     = 16'd6554;
   localparam logic [7:0]  MIN_REFRACTORY_RESET = 8'd6;
   localparam logic [15:0] AVERAGE_WEIGHT_RESET = 16'd655;

   localparam logic [15:0] STRENGTH_WEIGHT    = 16'd6554;
   localparam logic [15:0] NO_TEMPO_MAX       = 16'd256;
   localparam logic [15:0] STRENGTH_ZERO_AVG  = 16'd256;
   localparam logic [15:0] STRENGTH_SATURATED = 16'hFFFF;
   localparam logic [15:0] HOPS_SATURATED     = 16'hFFFF;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ONSET_FACTOR   = 2'd0,
      CSR_PHASE_GAIN     = 2'd1,
      CSR_MIN_REFRACTORY = 2'd2,
      CSR_AVERAGE_WEIGHT = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic [11:0] onset_factor;
      logic [15:0] phase_gain;
      logic [7:0]  min_refractory;
      logic [15:0] average_weight;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_status_type;

   typedef enum logic [2:0] {
      ALU_HOLD,
      ALU_LOAD,
      ALU_LOAD_OPD,
      ALU_MUL,
      ALU_DIV,
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_RUN,
      S_AVG_A,
      S_AVG_B,
      S_FAC,
      S_CMP,
      S_TEST,
      S_DIV,
      S_STR,
      S_WGT,
      S_GW,
      S_GWD,
      S_PER,
      S_ADV,
      S_SUM,
      S_ERR,
      S_NEG,
      S_MAG,
      S_COR,
      S_APPLY,
      S_FIX,
      S_WRAP,
      S_DONE
   } seq_state_type;

endpackage

// ===== src/obpt_alu.sv =====
// Shared add/subtract unit: shift-add multiply, restoring divide, add, subtract.
module obpt_alu import obpt_pkg::*; #(
   parameter int AW = 58,
   parameter int QW = 32
) (
   input  logic          clock,
   input  alu_op_type    op,
   input  logic [AW-1:0] acc_ld,
   input  logic [AW-1:0] opd_ld,
   input  logic [QW-1:0] q_ld,
   output logic [AW-1:0] acc,
   output logic [QW-1:0] q,
   output logic          ge
);

   logic [AW-1:0] acc_ff, acc_in;
   logic [AW-1:0] opd_ff, opd_in;
   logic [QW-1:0] q_ff, q_in;
   logic          sub_mode;
   logic [AW-1:0] opd_x;
   logic [AW:0]   sum;

   always_comb begin
      sub_mode = !(op == ALU_MUL || op == ALU_ADD);
      opd_x    = sub_mode ? ~opd_ff : opd_ff;
      sum      = {1'b0, acc_ff} + {1'b0, opd_x} + {{AW{1'b0}}, sub_mode};
      ge       = sum[AW];
   end

   always_comb begin
      acc_in = acc_ff;
      opd_in = opd_ff;
      q_in   = q_ff;
      unique case (op)
         ALU_HOLD: begin
         end
         ALU_LOAD: begin
            acc_in = acc_ld;
            opd_in = opd_ld;
            q_in   = q_ld;
         end
         ALU_LOAD_OPD: begin
            opd_in = opd_ld;
            q_in   = q_ld;
         end
         ALU_MUL: begin
            if (q_ff[0]) begin
               acc_in = sum[AW-1:0];
            end
            opd_in = opd_ff << 1;
            q_in   = q_ff >> 1;
         end
         ALU_DIV: begin
            if (ge) begin
               acc_in = sum[AW-1:0];
            end
            opd_in = opd_ff >> 1;
            q_in   = {q_ff[QW-2:0], ge};
         end
         ALU_ADD, ALU_SUB: begin
            acc_in = sum[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opd_ff <= opd_in;
      q_ff   <= q_in;
   end

   assign acc = acc_ff;
   assign q   = q_ff;

endmodule

// ===== src/obpt_csr.sv =====
// Configuration register file of the onset and beat phase tracker.
module obpt_csr import obpt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [CSR_INDEX_BITS-1:0] wr_index,
   input  logic [CSR_DATA_BITS-1:0]  wr_data,
   output cfg_type                   cfg
);

   cfg_type     cfg_ff, cfg_in;
   csr_reg_type reg_sel;

   always_comb begin
      reg_sel = csr_reg_type'(wr_index);
      cfg_in  = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_ONSET_FACTOR:   cfg_in.onset_factor   = wr_data[11:0];
            CSR_PHASE_GAIN:     cfg_in.phase_gain     = wr_data;
            CSR_MIN_REFRACTORY: cfg_in.min_refractory = wr_data[7:0];
            CSR_AVERAGE_WEIGHT: cfg_in.average_weight = wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.onset_factor   <= ONSET_FACTOR_RESET;
         cfg_ff.phase_gain     <= PHASE_GAIN_RESET;
         cfg_ff.min_refractory <= MIN_REFRACTORY_RESET;
         cfg_ff.average_weight <= AVERAGE_WEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/obpt_seq.sv =====
// Sequencer and tracker state: drives the shared unit through one hop.
module obpt_seq import obpt_pkg::*; #(
   parameter int FLUX_BITS  = 24,
   parameter int PHASE_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [FLUX_FIELD_BITS-1:0]  req_flux,
   input  logic [PERIOD_BITS-1:0]      req_period,
   input  cfg_type                     cfg,
   input  logic                        out_free,
   output seq_status_type              status,
   output logic                        onset,
   output logic                        beat,
   output logic [PHASE_TURNS_BITS-1:0] phase_turns,
   output logic [STRENGTH_BITS-1:0]    strength
);

   localparam int FB  = FLUX_BITS;
   localparam int PB  = PHASE_BITS;
   localparam int AVW = FB + 16;
   localparam int AW  = (FB + 34 > PB + 18) ? FB + 34 : PB + 18;
   localparam int QW  = (PB > 17) ? PB : 17;
   localparam int CW  = $clog2(QW + 1);

   seq_state_type state_ff, state_in;
   seq_state_type ret_ff, ret_in;
   alu_op_type    runop_ff, runop_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [FB-1:0]          flux_ff, flux_in;
   logic [PERIOD_BITS-1:0] period_ff, period_in;
   logic [AVW-1:0]         avg_ff, avg_in;
   logic [FB-1:0]          prev_ff, prev_in;
   logic [15:0]            hops_ff, hops_in;
   logic [PB-1:0]          phase_ff, phase_in;
   logic [PB+1:0]          s_ff, s_in;
   logic                   neg_ff, neg_in;
   logic                   onset_ff, onset_in;
   logic                   beat_ff, beat_in;
   logic [15:0]            strength_ff, strength_in;
   logic [15:0]            gw_ff, gw_in;

   alu_op_type    alu_op;
   logic [AW-1:0] acc_ld, opd_ld, acc;
   logic [QW-1:0] q_ld, q;
   logic          ge;

   logic [FB+23:0] flux_ext;
   logic           per_on;
   logic           onset_now;
   logic [PB-1:0]  r;
   logic           neg_now;
   logic           mag_small;
   logic [16:0]    weight;

   obpt_alu #(.AW(AW), .QW(QW)) u_alu (
      .clock  (clock),
      .op     (alu_op),
      .acc_ld (acc_ld),
      .opd_ld (opd_ld),
      .q_ld   (q_ld),
      .acc    (acc),
      .q      (q),
      .ge     (ge)
   );

   always_comb begin
      flux_ext  = {{FB{1'b0}}, req_flux};
      per_on    = period_ff > NO_TEMPO_MAX;
      onset_now = !ge && (flux_ff >= prev_ff) &&
                  (hops_ff >= {8'd0, cfg.min_refractory}) &&
                  (hops_ff >= {10'd0, period_ff[15:10]});
      r         = acc[PB-1:0];
      neg_now   = r[PB-1] & (|r[PB-2:0]);
      mag_small = (acc[PB-1:PB-2] == 2'b00);
      weight    = (acc[28:23] != 6'd0) ? 17'h10000 : {2'b01, acc[22:8]};
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      runop_in = runop_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_AVG_A;
            end
         end
         S_RUN: begin
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ret_ff;
            end
         end
         S_AVG_A: begin
            state_in = S_RUN;
            ret_in   = S_AVG_B;
            runop_in = ALU_MUL;
            cnt_in   = CW'(17);
         end
         S_AVG_B: begin
            state_in = S_RUN;
            ret_in   = S_FAC;
            runop_in = ALU_MUL;
            cnt_in   = CW'(16);
         end
         S_FAC: begin
            state_in = S_RUN;
            ret_in   = S_CMP;
            runop_in = ALU_MUL;
            cnt_in   = CW'(12);
         end
         S_CMP: state_in = S_TEST;
         S_TEST: begin
            state_in = (onset_now && avg_ff != '0) ? S_DIV : S_STR;
         end
         S_DIV: begin
            state_in = S_RUN;
            ret_in   = S_STR;
            runop_in = ALU_DIV;
            cnt_in   = CW'(17);
         end
         S_STR: state_in = (onset_ff && per_on) ? S_WGT : S_PER;
         S_WGT: begin
            state_in = S_RUN;
            ret_in   = S_GW;
            runop_in = ALU_MUL;
            cnt_in   = CW'(13);
         end
         S_GW: begin
            state_in = S_RUN;
            ret_in   = S_GWD;
            runop_in = ALU_MUL;
            cnt_in   = CW'(17);
         end
         S_GWD: state_in = S_PER;
         S_PER: begin
            if (per_on) begin
               state_in = S_RUN;
               ret_in   = S_ADV;
               runop_in = ALU_DIV;
               cnt_in   = CW'(PB);
            end else begin
               state_in = S_DONE;
            end
         end
         S_ADV: state_in = S_SUM;
         S_SUM: state_in = S_ERR;
         S_ERR: state_in = onset_ff ? S_NEG : S_WRAP;
         S_NEG: state_in = S_MAG;
         S_MAG: begin
            if (mag_small) begin
               state_in = S_RUN;
               ret_in   = S_COR;
               runop_in = ALU_MUL;
               cnt_in   = CW'(16);
            end else begin
               state_in = S_WRAP;
            end
         end
         S_COR:   state_in = S_APPLY;
         S_APPLY: state_in = S_FIX;
         S_FIX:   state_in = S_WRAP;
         S_WRAP:  state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      alu_op      = ALU_HOLD;
      acc_ld      = '0;
      opd_ld      = '0;
      q_ld        = '0;
      flux_in     = flux_ff;
      period_in   = period_ff;
      avg_in      = avg_ff;
      prev_in     = prev_ff;
      hops_in     = hops_ff;
      phase_in    = phase_ff;
      s_in        = s_ff;
      neg_in      = neg_ff;
      onset_in    = onset_ff;
      beat_in     = beat_ff;
      strength_in = strength_ff;
      gw_in       = gw_ff;
      status.idle = 1'b0;
      status.done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            status.idle = 1'b1;
            if (start) begin
               flux_in   = flux_ext[FB-1:0];
               period_in = req_period;
               onset_in  = 1'b0;
               beat_in   = 1'b0;
            end
         end
         S_RUN: alu_op = runop_ff;
         S_AVG_A: begin
            alu_op = ALU_LOAD;
            opd_ld = AW'(avg_ff);
            q_ld   = QW'(17'h10000 - {1'b0, cfg.average_weight});
         end
         S_AVG_B: begin
            alu_op = ALU_LOAD_OPD;
            opd_ld = AW'(flux_ff) << 16;
            q_ld   = QW'(cfg.average_weight);
         end
         S_FAC: begin
            avg_in  = acc[AVW+15:16];
            hops_in = (hops_ff == HOPS_SATURATED) ? hops_ff : hops_ff + 16'd1;
            alu_op  = ALU_LOAD;
            opd_ld  = AW'(acc[AVW+15:16]);
            q_ld    = QW'(cfg.onset_factor);
         end
         S_CMP: begin
            alu_op = ALU_LOAD_OPD;
            opd_ld = AW'(flux_ff) << 24;
         end
         S_TEST: begin
            onset_in = onset_now;
            prev_in  = flux_ff;
            if (onset_now) begin
               hops_in = 16'd0;
            end
         end
         S_DIV: begin
            alu_op = ALU_LOAD;
            acc_ld = AW'(flux_ff) << 24;
            opd_ld = AW'(avg_ff) << 16;
         end
         S_STR: begin
            if (!onset_ff) begin
               strength_in = 16'd0;
            end else if (avg_ff == '0) begin
               strength_in = STRENGTH_ZERO_AVG;
            end else if (q[16]) begin
               strength_in = STRENGTH_SATURATED;
            end else begin
               strength_in = q[15:0];
            end
         end
         S_WGT: begin
            alu_op = ALU_LOAD;
            opd_ld = AW'(strength_ff);
            q_ld   = QW'(STRENGTH_WEIGHT);
         end
         S_GW: begin
            alu_op = ALU_LOAD;
            opd_ld = AW'(cfg.phase_gain);
            q_ld   = QW'(weight);
         end
         S_GWD: gw_in = acc[31:16];
         S_PER: begin
            if (per_on) begin
               alu_op = ALU_LOAD;
               acc_ld = AW'(1) << (PB + 8);
               opd_ld = AW'(period_ff) << (PB - 1);
            end
         end
         S_ADV: begin
            alu_op = ALU_LOAD;
            acc_ld = AW'(phase_ff);
            opd_ld = AW'(q[PB-1:0]);
         end
         S_SUM: alu_op = ALU_ADD;
         S_ERR: begin
            s_in   = acc[PB+1:0];
            neg_in = neg_now;
            alu_op = ALU_LOAD;
            acc_ld = neg_now ? (AW'(1) << PB) : AW'(r);
            opd_ld = neg_now ? AW'(r) : '0;
         end
         S_NEG: alu_op = ALU_SUB;
         S_MAG: begin
            alu_op = ALU_LOAD;
            opd_ld = AW'(acc[PB-1:0]);
            q_ld   = QW'(gw_ff);
         end
         S_COR: begin
            alu_op = ALU_LOAD;
            acc_ld = AW'(s_ff);
            opd_ld = AW'(acc[PB+15:16]);
         end
         S_APPLY: alu_op = neg_ff ? ALU_ADD : ALU_SUB;
         S_FIX:   s_in = acc[PB+1:0];
         S_WRAP: begin
            beat_in  = |s_ff[PB+1:PB];
            phase_in = s_ff[PB-1:0];
         end
         S_DONE: status.done = out_free;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         runop_ff <= ALU_HOLD;
         cnt_ff   <= '0;
         avg_ff   <= '0;
         prev_ff  <= '0;
         hops_ff  <= '0;
         phase_ff <= '0;
         onset_ff <= 1'b0;
         beat_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         runop_ff <= runop_in;
         cnt_ff   <= cnt_in;
         avg_ff   <= avg_in;
         prev_ff  <= prev_in;
         hops_ff  <= hops_in;
         phase_ff <= phase_in;
         onset_ff <= onset_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      flux_ff     <= flux_in;
      period_ff   <= period_in;
      s_ff        <= s_in;
      neg_ff      <= neg_in;
      strength_ff <= strength_in;
      gw_ff       <= gw_in;
   end

   if (PB >= PHASE_TURNS_BITS) begin : g_phase_trunc
      assign phase_turns = phase_ff[PB-1 -: PHASE_TURNS_BITS];
   end else begin : g_phase_pad
      assign phase_turns = {phase_ff, {(PHASE_TURNS_BITS-PB){1'b0}}};
   end

   assign onset    = onset_ff;
   assign beat     = beat_ff;
   assign strength = strength_ff;

endmodule

// ===== src/onset_beat_phase_tracker_core.sv =====
// Top level of the onset detector and beat phase tracker.
//
//   channel  dir  handshake                 payload
//   req      in   req_tvalid / req_tready   req_tdata: flux, period_hops_q8
//   rsp      out  rsp_tvalid / rsp_tready   rsp_tdata: onset, beat, phase, strength
//   csr      in   csr_valid / csr_ready     csr_index, csr_data
//
// The shared add/subtract unit resolves one multiplier or quotient bit per cycle.
// Reset is synchronous; configuration returns to its defaults and tracker state to zero.
// A finished result waits in the output register; the next hop is taken meanwhile.
module onset_beat_phase_tracker_core import obpt_pkg::*; #(
   parameter int FLUX_BITS  = 24,
   parameter int PHASE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // flux[23:0], period_hops_q8[39:24]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // onset[0], beat[1], phase_turns[33:2],
                                                  // strength_q8[49:34], zero[55:50]
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type                     cfg;
   seq_status_type              status;
   logic                        out_free;
   logic                        onset, beat;
   logic [PHASE_TURNS_BITS-1:0] phase_turns;
   logic [STRENGTH_BITS-1:0]    strength;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   obpt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   obpt_seq #(.FLUX_BITS(FLUX_BITS), .PHASE_BITS(PHASE_BITS)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_tvalid),
      .req_flux    (req_tdata[FLUX_FIELD_BITS-1:0]),
      .req_period  (req_tdata[FLUX_FIELD_BITS +: PERIOD_BITS]),
      .cfg         (cfg),
      .out_free    (out_free),
      .status      (status),
      .onset       (onset),
      .beat        (beat),
      .phase_turns (phase_turns),
      .strength    (strength)
   );

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (status.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, strength, phase_turns, beat, onset};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = status.idle;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("tracker ready right after taking a transaction");

   a_done_needs_room: assert property (@(posedge clock) disable iff (reset)
      status.done |-> (!rsp_tvalid || rsp_tready))
      else $error("result finished while output register is blocked");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(status.done))
      else $error("result transaction raised without a finished hop");

   a_one_done_per_item: assert property (@(posedge clock) disable iff (reset)
      status.done |-> !req_tready)
      else $error("result finished while sequencer idle");

endmodule
